// ----- rtl/quaternion_to_euler_angles_macros.svh -----
// ----------------------------------------------------------------------------
// quaternion to euler angles assertion macros
// shared concurrent assertion forms for the rtl folder
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// same-cycle implication
`define QTEA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QTEA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/qtea_pkg.sv -----
// ----------------------------------------------------------------------------
// qtea_pkg
// widths, constants and types shared by the quaternion to euler datapath
// ----------------------------------------------------------------------------
package qtea_pkg;

	localparam int QW      = 16;
	localparam int PRW     = 32;
	localparam int SW      = 34;
	localparam int CW      = 37;
	localparam int ZW      = 21;
	localparam int AW      = 22;
	localparam int PW      = 52;
	localparam int NLANE   = 3;
	localparam int CSTEPS  = 16;
	localparam int SQ_IN_W = 38;
	localparam int SQ_W    = 19;
	localparam int SQ_RW   = 22;
	localparam int OUT_W   = 94;

	localparam int LN_ROLL  = 0;
	localparam int LN_PITCH = 1;
	localparam int LN_YAW   = 2;

	localparam logic signed [SW-1:0] ONE_Q28 = {{(SW-29){1'b0}}, 1'b1, 28'd0};
	localparam logic signed [ZW-1:0] PI_Q16 = 21'sd205887;
	localparam logic signed [AW-1:0] HALF_PI_Q16 = 22'sd102944;
	localparam logic signed [PW-1:0] DEG_K = 52'sd480631834;
	localparam logic signed [PW-1:0] DEG_RND = 52'sd2147483648;
	localparam logic signed [AW-1:0] HEAD_OFS = 22'sd23040;

	localparam logic signed [ZW-1:0] ATAN_TAB [CSTEPS] = '{
		21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150, 21'sd4091, 21'sd2047,
		21'sd1024, 21'sd512, 21'sd256, 21'sd128, 21'sd64, 21'sd32,
		21'sd16, 21'sd8, 21'sd4, 21'sd2
	};

	localparam logic signed [AW-1:0] RAD_LIM [NLANE] = '{22'sd25736, 22'sd12868, 22'sd25736};
	localparam logic signed [AW-1:0] DEG_LIM [NLANE] = '{22'sd23040, 22'sd11520, 22'sd23040};

	typedef struct packed {
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] x;
	} qtea_vec_t;

	function automatic logic signed [AW-1:0] sat_ang(logic signed [AW-1:0] v,
			logic signed [AW-1:0] lim);
		logic signed [AW-1:0] r;
		r = v;
		if (v > lim) r = lim;
		if (v < -lim) r = -lim;
		return r;
	endfunction

endpackage

// ----- rtl/qtea_isqrt.sv -----
// ----------------------------------------------------------------------------
// qtea_isqrt
// two-lane pipelined restoring integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module qtea_isqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [1:0][qtea_pkg::SQ_IN_W-1:0] op_in,
	output logic out_valid,
	output logic [1:0][qtea_pkg::SQ_W-1:0] root_out
);

	logic [qtea_pkg::SQ_IN_W-1:0] op_s   [qtea_pkg::SQ_W][2];
	logic [qtea_pkg::SQ_RW-1:0]   rem_s  [qtea_pkg::SQ_W][2];
	logic [qtea_pkg::SQ_W-1:0]    root_s [qtea_pkg::SQ_W][2];
	logic [qtea_pkg::SQ_W-1:0]    v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[qtea_pkg::SQ_W-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < qtea_pkg::SQ_W; k++) begin : g_step
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [qtea_pkg::SQ_IN_W-1:0] op_c;
			logic [qtea_pkg::SQ_RW-1:0] rem_c, rem_n, trial;
			logic [qtea_pkg::SQ_W-1:0] root_c;
			logic ge;

			if (k == 0) begin : g_first
				assign op_c   = op_in[l];
				assign rem_c  = '0;
				assign root_c = '0;
			end else begin : g_next
				assign op_c   = op_s[k-1][l];
				assign rem_c  = rem_s[k-1][l];
				assign root_c = root_s[k-1][l];
			end

			assign rem_n = {rem_c[qtea_pkg::SQ_RW-3:0], op_c[qtea_pkg::SQ_IN_W-1 -: 2]};
			assign trial = {1'b0, root_c, 2'b01};
			assign ge    = (rem_n >= trial);

			always_ff @(posedge clk) begin
				if (en) begin
					op_s[k][l]   <= {op_c[qtea_pkg::SQ_IN_W-3:0], 2'b00};
					rem_s[k][l]  <= ge ? (rem_n - trial) : rem_n;
					root_s[k][l] <= {root_c[qtea_pkg::SQ_W-2:0], ge};
				end
			end
		end
	end

	assign out_valid   = v_s[qtea_pkg::SQ_W-1];
	assign root_out[0] = root_s[qtea_pkg::SQ_W-1][0];
	assign root_out[1] = root_s[qtea_pkg::SQ_W-1][1];

endmodule

// ----- rtl/qtea_cordic.sv -----
// ----------------------------------------------------------------------------
// qtea_cordic
// multi-lane pipelined vectoring cordic giving atan2 in q16 radians
// ----------------------------------------------------------------------------
module qtea_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  qtea_pkg::qtea_vec_t [qtea_pkg::NLANE-1:0] vec_in,
	output logic out_valid,
	output logic [qtea_pkg::NLANE-1:0][qtea_pkg::ZW-1:0] ang_out
);

	logic signed [qtea_pkg::CW-1:0] x_s [qtea_pkg::CSTEPS+1][qtea_pkg::NLANE];
	logic signed [qtea_pkg::CW-1:0] y_s [qtea_pkg::CSTEPS+1][qtea_pkg::NLANE];
	logic signed [qtea_pkg::ZW-1:0] z_s [qtea_pkg::CSTEPS+1][qtea_pkg::NLANE];
	logic zero_s [qtea_pkg::CSTEPS+1][qtea_pkg::NLANE];
	logic [qtea_pkg::CSTEPS:0] v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[qtea_pkg::CSTEPS-1:0], in_valid};
		end
	end

	// left half-plane folded by a half turn
	for (genvar l = 0; l < qtea_pkg::NLANE; l++) begin : g_pre
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[0][l] <= (vec_in[l].x == '0) && (vec_in[l].y == '0);
				if (vec_in[l].x[qtea_pkg::CW-1]) begin
					x_s[0][l] <= -vec_in[l].x;
					y_s[0][l] <= -vec_in[l].y;
					z_s[0][l] <= vec_in[l].y[qtea_pkg::CW-1] ? -qtea_pkg::PI_Q16
						: qtea_pkg::PI_Q16;
				end else begin
					x_s[0][l] <= vec_in[l].x;
					y_s[0][l] <= vec_in[l].y;
					z_s[0][l] <= '0;
				end
			end
		end
	end

	for (genvar k = 0; k < qtea_pkg::CSTEPS; k++) begin : g_step
		for (genvar l = 0; l < qtea_pkg::NLANE; l++) begin : g_lane
			logic signed [qtea_pkg::CW-1:0] dx, dy;
			assign dx = x_s[k][l] >>> k;
			assign dy = y_s[k][l] >>> k;

			always_ff @(posedge clk) begin
				if (en) begin
					zero_s[k+1][l] <= zero_s[k][l];
					if (!y_s[k][l][qtea_pkg::CW-1]) begin
						x_s[k+1][l] <= x_s[k][l] + dy;
						y_s[k+1][l] <= y_s[k][l] - dx;
						z_s[k+1][l] <= z_s[k][l] + qtea_pkg::ATAN_TAB[k];
					end else begin
						x_s[k+1][l] <= x_s[k][l] - dy;
						y_s[k+1][l] <= y_s[k][l] + dx;
						z_s[k+1][l] <= z_s[k][l] - qtea_pkg::ATAN_TAB[k];
					end
				end
			end
		end
	end

	for (genvar l = 0; l < qtea_pkg::NLANE; l++) begin : g_out
		assign ang_out[l] = zero_s[qtea_pkg::CSTEPS][l] ? '0 : z_s[qtea_pkg::CSTEPS][l];
	end

	assign out_valid = v_s[qtea_pkg::CSTEPS];

endmodule

// ----- rtl/quaternion_to_euler_angles.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Usage: one unit quaternion (w, x, y, z, signed q1.14) enters per s_tdata
// beat; one beat leaves on m_tdata with roll, pitch and yaw in q3.13 radians,
// roll and pitch in degrees*128, and the heading as 180 minus yaw in
// degrees*128 (0 to 360).
// Throughput: one beat per cycle while the output queue is not full, since
// every stage is a register and items do not depend on each other.
// Path from an input beat to its output beat, through registered stages:
// products and sums, the square root (one root bit per stage), the
// cordic (one fold plus 16 rotations), scaling and one output register.
// The output side is a two-entry queue; s_tready drops only while both
// entries hold beats the receiver has not taken, and the whole pipeline then
// holds still, losing and repeating nothing.
// Reset clears all valid bits and the queue; no beat is in flight after it.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_macros.svh"

module quaternion_to_euler_angles (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // quat_w, quat_x, quat_y, quat_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata   // roll_rad, pitch_rad, yaw_rad, roll_deg,
	                              // pitch_deg, heading_deg, zero pad
);

	logic en;
	logic [1:0] cnt_q;
	logic wr_q, rd_q;
	logic [qtea_pkg::OUT_W-1:0] fifo_q [2];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [qtea_pkg::QW-1:0] w_s1, x_s1, y_s1, z_s1;
	logic signed [qtea_pkg::PRW-1:0] wx_s2, yz_s2, xx_s2, yy_s2, wz_s2, xy_s2, zz_s2,
		wy_s2, xz_s2;
	qtea_pkg::qtea_vec_t roll_s3, yaw_s3;
	logic [1:0][qtea_pkg::SQ_IN_W-1:0] sq_s3;
	qtea_pkg::qtea_vec_t roll_dly_s [qtea_pkg::SQ_W];
	qtea_pkg::qtea_vec_t yaw_dly_s [qtea_pkg::SQ_W];

	logic sq_valid;
	logic [1:0][qtea_pkg::SQ_W-1:0] sq_root;
	qtea_pkg::qtea_vec_t [qtea_pkg::NLANE-1:0] cv_in;
	logic cv_valid;
	logic [qtea_pkg::NLANE-1:0][qtea_pkg::ZW-1:0] cv_ang;

	logic signed [qtea_pkg::AW-1:0] ang_s4 [qtea_pkg::NLANE];
	logic [15:0] rad_s5 [qtea_pkg::NLANE];
	logic signed [qtea_pkg::PW-1:0] mul_s5 [qtea_pkg::NLANE];

	logic [15:0] deg_c [qtea_pkg::NLANE];
	logic signed [qtea_pkg::AW-1:0] heading_c;
	logic [qtea_pkg::OUT_W-1:0] entry_c;
	logic push, pop;

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {2'b00, fifo_q[rd_q]};
	assign push     = en && v_s5;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= cv_valid;
			v_s5 <= v_s4;
		end
	end

	// input beat and products
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= s_tdata[15:0];
			x_s1 <= s_tdata[31:16];
			y_s1 <= s_tdata[47:32];
			z_s1 <= s_tdata[63:48];
			wx_s2 <= w_s1 * x_s1;
			yz_s2 <= y_s1 * z_s1;
			xx_s2 <= x_s1 * x_s1;
			yy_s2 <= y_s1 * y_s1;
			wz_s2 <= w_s1 * z_s1;
			xy_s2 <= x_s1 * y_s1;
			zz_s2 <= z_s1 * z_s1;
			wy_s2 <= w_s1 * y_s1;
			xz_s2 <= x_s1 * z_s1;
		end
	end

	// atan2 operands and square root arguments
	always_ff @(posedge clk) begin
		logic signed [qtea_pkg::SW-1:0] tt;
		logic signed [qtea_pkg::SW:0] pa, pb;
		if (en) begin
			roll_s3.y <= qtea_pkg::CW'((qtea_pkg::SW'(wx_s2) + qtea_pkg::SW'(yz_s2)) <<< 1);
			roll_s3.x <= qtea_pkg::CW'(qtea_pkg::ONE_Q28
				- ((qtea_pkg::SW'(xx_s2) + qtea_pkg::SW'(yy_s2)) <<< 1));
			yaw_s3.y <= qtea_pkg::CW'((qtea_pkg::SW'(wz_s2) + qtea_pkg::SW'(xy_s2)) <<< 1);
			yaw_s3.x <= qtea_pkg::CW'(qtea_pkg::ONE_Q28
				- ((qtea_pkg::SW'(yy_s2) + qtea_pkg::SW'(zz_s2)) <<< 1));
			tt = (qtea_pkg::SW'(wy_s2) - qtea_pkg::SW'(xz_s2)) <<< 1;
			pa = (qtea_pkg::SW+1)'(qtea_pkg::ONE_Q28) + (qtea_pkg::SW+1)'(tt);
			pb = (qtea_pkg::SW+1)'(qtea_pkg::ONE_Q28) - (qtea_pkg::SW+1)'(tt);
			// negative arguments clamp to zero
			sq_s3[0] <= pa[qtea_pkg::SW] ? '0
				: {1'b0, pa[qtea_pkg::SQ_IN_W-6:0], 4'b0000};
			sq_s3[1] <= pb[qtea_pkg::SW] ? '0
				: {1'b0, pb[qtea_pkg::SQ_IN_W-6:0], 4'b0000};
		end
	end

	qtea_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.op_in     (sq_s3),
		.out_valid (sq_valid),
		.root_out  (sq_root)
	);

	// roll and yaw wait out the square root
	for (genvar k = 0; k < qtea_pkg::SQ_W; k++) begin : g_dly
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					roll_dly_s[k] <= roll_s3;
					yaw_dly_s[k]  <= yaw_s3;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					roll_dly_s[k] <= roll_dly_s[k-1];
					yaw_dly_s[k]  <= yaw_dly_s[k-1];
				end
			end
		end
	end

	always_comb begin
		cv_in[qtea_pkg::LN_ROLL]    = roll_dly_s[qtea_pkg::SQ_W-1];
		cv_in[qtea_pkg::LN_YAW]     = yaw_dly_s[qtea_pkg::SQ_W-1];
		cv_in[qtea_pkg::LN_PITCH].y = qtea_pkg::CW'($signed({1'b0, sq_root[0]}));
		cv_in[qtea_pkg::LN_PITCH].x = qtea_pkg::CW'($signed({1'b0, sq_root[1]}));
	end

	qtea_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.vec_in    (cv_in),
		.out_valid (cv_valid),
		.ang_out   (cv_ang)
	);

	// angles in q16, then q3.13 radians and degree products
	always_ff @(posedge clk) begin
		if (en) begin
			ang_s4[qtea_pkg::LN_ROLL] <= qtea_pkg::AW'($signed(cv_ang[qtea_pkg::LN_ROLL]));
			ang_s4[qtea_pkg::LN_YAW]  <= qtea_pkg::AW'($signed(cv_ang[qtea_pkg::LN_YAW]));
			ang_s4[qtea_pkg::LN_PITCH] <=
				(qtea_pkg::AW'($signed(cv_ang[qtea_pkg::LN_PITCH])) <<< 1)
				- qtea_pkg::HALF_PI_Q16;
		end
	end

	for (genvar l = 0; l < qtea_pkg::NLANE; l++) begin : g_scale
		logic signed [qtea_pkg::AW-1:0] rad_c, rad_sat;
		logic signed [qtea_pkg::PW-1:0] rnd_c;
		logic signed [qtea_pkg::AW-1:0] deg_sat;

		assign rad_c   = (ang_s4[l] + qtea_pkg::AW'(4)) >>> 3;
		assign rad_sat = qtea_pkg::sat_ang(rad_c, qtea_pkg::RAD_LIM[l]);

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s5[l] <= rad_sat[15:0];
				mul_s5[l] <= qtea_pkg::PW'(ang_s4[l]) * qtea_pkg::DEG_K;
			end
		end

		assign rnd_c   = mul_s5[l] + qtea_pkg::DEG_RND;
		assign deg_sat = qtea_pkg::sat_ang(
			qtea_pkg::AW'($signed(rnd_c[qtea_pkg::PW-1:32])), qtea_pkg::DEG_LIM[l]);
		assign deg_c[l] = deg_sat[15:0];

		if (l == qtea_pkg::LN_YAW) begin : g_head
			assign heading_c = qtea_pkg::HEAD_OFS - deg_sat;
		end
	end

	assign entry_c = {heading_c[15:0], deg_c[qtea_pkg::LN_PITCH][14:0],
		deg_c[qtea_pkg::LN_ROLL], rad_s5[qtea_pkg::LN_YAW],
		rad_s5[qtea_pkg::LN_PITCH][14:0], rad_s5[qtea_pkg::LN_ROLL]};

	// output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= entry_c;
		end
	end

	`QTEA_ASSERT_NXT(a_full_holds, clk, arst_n, (cnt_q == 2'd2) && !m_tready, cnt_q == 2'd2, "full queue changed without a beat taken")
	`QTEA_ASSERT_IMP(a_heading_range, clk, arst_n, m_tvalid, m_tdata[93:78] <= 16'd46080, "heading out of range")
	`QTEA_ASSERT_IMP(a_pitch_range, clk, arst_n, m_tvalid, ($signed(m_tdata[30:16]) <= 15'sd12868) && ($signed(m_tdata[30:16]) >= -15'sd12868), "pitch radians out of range")

endmodule
